### hdl/lpde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpde_pkg;

   localparam int unsigned PACKETS_PER_CAPTURE = 10;

   localparam logic [7:0] SYNC_BYTE           = 8'hFA;
   localparam logic [7:0] INDEX_LOW           = 8'hA0;
   localparam logic [7:0] INDEX_HIGH          = 8'hF9;
   localparam logic [7:0] INVALID_ABOVE_RESET = 8'h18;

   localparam logic [4:0] HUNT_LAST   = 5'd22;
   localparam logic [4:0] PACKET_LAST = 5'd21;
   localparam logic [4:0] INDEX_POS   = 5'd1;
   localparam logic [4:0] FIRST_POS   = 5'd2;
   localparam logic [4:0] LOW_FIRST   = 5'd4;
   localparam logic [4:0] LOW_LAST    = 5'd16;
   localparam logic [4:0] HIGH_FIRST  = 5'd5;
   localparam logic [4:0] HIGH_LAST   = 5'd17;
   localparam logic [3:0] LAST_PACKET = 4'(PACKETS_PER_CAPTURE - 1);

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam int unsigned CSR_AW = 3;
   localparam logic REG_INVALID_ABOVE = 1'b0;

   typedef enum logic [3:0] {
      PHASE_IDLE = 4'b0001,
      PHASE_HUNT = 4'b0010,
      PHASE_WALK = 4'b0100,
      PHASE_DONE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_capture;
      logic       no_sync;
   } result_type;

   typedef struct packed {
      logic       first;
      logic       second;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

`default_nettype wire

### hdl/lpde_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpde_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_capture;

   modport source (output valid, output data_byte, output first_of_capture, input ready);
   modport sink (input valid, input data_byte, input first_of_capture, output ready);
endinterface

`default_nettype wire

### hdl/lpde_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_capture;
   logic       no_sync;

   modport source (output valid, output out_byte, output last_of_capture, output no_sync,
                   input ready);
   modport sink (input valid, input out_byte, input last_of_capture, input no_sync,
                 output ready);
endinterface

`default_nettype wire

### hdl/lpde_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module lpde_parse
   import lpde_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       first_of_capture,
   input  wire logic [7:0] invalid_above,
   output push_type        push
);

   phase_type  phase_ff, phase_in, cur_phase;
   logic [7:0] prev_ff;
   logic [4:0] hunt_ff, hunt_in, cur_hunt;
   logic [4:0] pos_ff, pos_in, cur_pos;
   logic [3:0] count_ff, count_in, cur_count;
   logic [7:0] held_ff, held_in;
   logic       sync_match, is_low, is_high, is_last, bad;

   // a first byte restarts the hunt before it is looked at
   assign cur_phase = first_of_capture ? PHASE_HUNT : phase_ff;
   assign cur_hunt  = first_of_capture ? 5'd0 : hunt_ff;
   assign cur_pos   = first_of_capture ? 5'd0 : pos_ff;
   assign cur_count = first_of_capture ? 4'd0 : count_ff;

   assign sync_match = (cur_hunt != 5'd0) && (prev_ff == SYNC_BYTE) &&
                       (data_byte >= INDEX_LOW) && (data_byte <= INDEX_HIGH);
   assign is_low  = (cur_pos[1:0] == 2'd0) && (cur_pos >= LOW_FIRST) && (cur_pos <= LOW_LAST);
   assign is_high = (cur_pos[1:0] == 2'd1) && (cur_pos >= HIGH_FIRST) &&
                    (cur_pos <= HIGH_LAST);
   assign is_last = (cur_pos == HIGH_LAST) && (cur_count >= LAST_PACKET);
   assign bad     = data_byte > invalid_above;

   always_comb begin
      push     = '0;
      phase_in = cur_phase;
      hunt_in  = cur_hunt;
      pos_in   = cur_pos;
      count_in = cur_count;
      held_in  = held_ff;
      unique case (cur_phase)
         PHASE_HUNT: begin
            priority if (sync_match) begin
               push.first = 1'b1;
               push.res0  = '{out_byte: data_byte, last_of_capture: 1'b0, no_sync: 1'b0};
               phase_in   = PHASE_WALK;
               pos_in     = FIRST_POS;
               count_in   = 4'd0;
            end else if (cur_hunt >= HUNT_LAST) begin
               push.first = 1'b1;
               push.res0  = '{out_byte: 8'd0, last_of_capture: 1'b1, no_sync: 1'b1};
               phase_in   = PHASE_DONE;
            end else begin
               hunt_in = cur_hunt + 5'd1;
            end
         end
         PHASE_WALK: begin
            if (cur_pos == INDEX_POS) begin
               push.first = 1'b1;
               push.res0  = '{out_byte: data_byte, last_of_capture: 1'b0, no_sync: 1'b0};
            end
            if (is_low) begin
               held_in = data_byte;
            end
            if (is_high) begin
               push.first = 1'b1;
               push.second = 1'b1;
               push.res0 = '{out_byte: (bad ? 8'd0 : held_ff), last_of_capture: 1'b0,
                             no_sync: 1'b0};
               push.res1 = '{out_byte: (bad ? 8'd0 : data_byte), last_of_capture: is_last,
                             no_sync: 1'b0};
            end
            priority if (is_high && is_last) begin
               phase_in = PHASE_DONE;
            end else if (cur_pos >= PACKET_LAST) begin
               pos_in   = 5'd0;
               count_in = cur_count + 4'd1;
            end else begin
               pos_in = cur_pos + 5'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         prev_ff  <= 8'd0;
         hunt_ff  <= 5'd0;
         pos_ff   <= 5'd0;
         count_ff <= 4'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         prev_ff  <= data_byte;
         hunt_ff  <= hunt_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

### hdl/lpde_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module lpde_fifo
   import lpde_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire push_type         push,
   input  wire logic             pop,
   output result_type            head,
   output logic                  not_empty,
   output logic [FIFO_CW-1:0]    fill
);

   result_type           entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_CW-1:0]   fill_ff, fill_in;
   logic [FIFO_AW-1:0]   wr_next;

   assign wr_next = wr_ff + FIFO_AW'(1);

   always_comb begin
      wr_in   = wr_ff + FIFO_AW'(push.first) + FIFO_AW'(push.second);
      rd_in   = rd_ff + FIFO_AW'(pop);
      fill_in = fill_ff + FIFO_CW'(push.first) + FIFO_CW'(push.second) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ff] <= push.res0;
      end
      if (push.second) begin
         entry_ff[wr_next] <= push.res1;
      end
   end

   assign head      = entry_ff[rd_ff];
   assign not_empty = fill_ff != '0;
   assign fill      = fill_ff;

endmodule

`default_nettype wire

### hdl/lidar_packet_distance_extractor.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  payload
// req_bus   in         data_byte[7:0], first_of_capture
// rsp_bus   out        out_byte[7:0], last_of_capture, no_sync
// csr_*     in/out     apb write/read of invalid_above at byte address 0
//
// a byte is registered in the input stage; its results (two for a distance high byte)
// are then written into the result queue, whose head drives rsp_bus.
// the queue drains one rsp beat per cycle while rsp_bus.ready is high; the input
// stage takes one byte per cycle while the queue has room for two results.
// reset is synchronous; it clears the parser state, the queue and invalid_above (24).
// a stalled rsp side backs up through the 4-entry queue into req_bus.ready.
module lidar_packet_distance_extractor
   import lpde_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   lpde_req_if.sink               req_bus,
   lpde_rsp_if.source             rsp_bus,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic               stage_valid_ff, stage_valid_in;
   logic [7:0]         stage_byte_ff;
   logic               stage_first_ff;
   logic               advance;
   logic               accept;
   logic [7:0]         invalid_above_ff;
   push_type           parse_push;
   push_type           queue_push;
   result_type         head;
   logic               not_empty;
   logic [FIFO_CW-1:0] fill;
   logic               pop;

   // room for two results keeps the queue from overflowing
   assign advance = stage_valid_ff && (fill <= FIFO_CW'(FIFO_DEPTH - 2));
   assign req_bus.ready = !stage_valid_ff || advance;
   assign accept = req_bus.valid && req_bus.ready;
   assign stage_valid_in = accept || (stage_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_byte_ff  <= req_bus.data_byte;
         stage_first_ff <= req_bus.first_of_capture;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invalid_above_ff <= INVALID_ABOVE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == REG_INVALID_ABOVE) begin
         invalid_above_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[2] == REG_INVALID_ABOVE) ? {24'd0, invalid_above_ff} : 32'd0;

   lpde_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .data_byte        (stage_byte_ff),
      .first_of_capture (stage_first_ff),
      .invalid_above    (invalid_above_ff),
      .push             (parse_push)
   );

   always_comb begin
      queue_push        = parse_push;
      queue_push.first  = parse_push.first && advance;
      queue_push.second = parse_push.second && advance;
   end

   assign pop = rsp_bus.valid && rsp_bus.ready;

   lpde_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .fill      (fill)
   );

   assign rsp_bus.valid           = not_empty;
   assign rsp_bus.out_byte        = head.out_byte;
   assign rsp_bus.last_of_capture = head.last_of_capture;
   assign rsp_bus.no_sync         = head.no_sync;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= FIFO_CW'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      queue_push.second |-> queue_push.first)
      else $error("second result pushed without first");

   a_no_sync_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.no_sync) |-> rsp_bus.last_of_capture)
      else $error("no_sync result not marked last");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(stage_byte_ff)))
      else $error("stalled input stage lost its byte");

endmodule

`default_nettype wire
